// ===== sv/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Frame layout
  localparam int unsigned PAYLOAD_LEN = 6;
  localparam int unsigned CNT_W       = $clog2(PAYLOAD_LEN);

  // Header bytes, in order of arrival
  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'h55;
  localparam logic [7:0] HDR2 = 8'h0B;
  localparam logic [7:0] HDR3 = 8'hC0;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ALT_W   = 16;
  localparam int unsigned IN_W    = 40;  // rx_byte + arrival_time, whole bytes
  localparam int unsigned OUT_W   = 80;  // result fields, whole bytes

  // Deframer phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_HDR2    = 3'd2,
    PH_HDR3    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_e;

endpackage

// ===== sv/sensor_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Byte-serial deframer for an eleven-byte sensor frame with checksum.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one received byte per transaction together with
//   its microsecond arrival time. The block hunts for the header AA 55 0B C0,
//   collects six payload bytes and a checksum byte, and emits one result
//   transaction on the master channel for each frame whose 8-bit byte sum is
//   zero. Bad frames and non-frame bytes produce nothing.
//   Each accepted start byte updates the start-to-start interval, which is
//   reported with the next good frame; tuser flags that two starts were seen.
//   Throughput: one byte per clock unless the output stalls. Each byte is
//   handled by next-state logic off the phase and checksum registers.
//   The result is valid in the cycle after the checksum byte's
//   transaction, from the output register.
//   Reset returns the block to the hunt with the checksum, interval and
//   start history cleared and the output register empty.
//   While a result waits in the output register, bytes keep flowing; only
//   when it is full and the receiver stalls is s_axis_tready held low.
// ----------------------------------------------------------------------------
module sensor_frame_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Received bytes
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [sfd_pkg::IN_W-1:0]   s_axis_tdata,   // [7:0] rx_byte, [39:8] arrival_time
  // Decoded frames
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [sfd_pkg::OUT_W-1:0]  m_axis_tdata,   // [7:0] flag_byte, [23:8] altitude_one,
                                                     // [39:24] altitude_two,
                                                     // [47:40] spare_byte,
                                                     // [79:48] frame_interval
  output logic                       m_axis_tuser    // [0] interval_valid
);

  // Input fields
  logic [sfd_pkg::BYTE_W-1:0] rx_byte;
  logic [sfd_pkg::TIME_W-1:0] arrival_time;
  assign rx_byte      = s_axis_tdata[sfd_pkg::BYTE_W-1:0];
  assign arrival_time = s_axis_tdata[sfd_pkg::BYTE_W +: sfd_pkg::TIME_W];

  // State
  sfd_pkg::phase_e             phase_q, phase_d;
  logic [sfd_pkg::BYTE_W-1:0]  sum_q, sum_d;
  logic [sfd_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [sfd_pkg::BYTE_W-1:0]  store_q [sfd_pkg::PAYLOAD_LEN];
  logic                        seen_start_q, seen_start_d;
  logic                        second_start_q, second_start_d;
  logic [sfd_pkg::TIME_W-1:0]  last_start_q, last_start_d;
  logic [sfd_pkg::TIME_W-1:0]  interval_q, interval_d;

  // Output register
  logic                        out_valid_q;
  logic [sfd_pkg::OUT_W-1:0]   out_data_q;
  logic                        out_user_q;

  logic                        in_fire;
  logic                        store_we;
  logic                        frame_good;
  logic [sfd_pkg::BYTE_W-1:0]  byte_sum;

  // Take a byte unless a result is stuck in the output register
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign byte_sum      = sum_q + rx_byte;
  assign store_we      = in_fire && (phase_q == sfd_pkg::PH_PAYLOAD);

  // Next state for one byte
  always_comb begin
    phase_d        = phase_q;
    sum_d          = sum_q;
    cnt_d          = cnt_q;
    seen_start_d   = seen_start_q;
    second_start_d = second_start_q;
    last_start_d   = last_start_q;
    interval_d     = interval_q;
    frame_good     = 1'b0;
    if (in_fire) begin
      case (phase_q)
        sfd_pkg::PH_HUNT: begin
          if (rx_byte == sfd_pkg::HDR0) begin
            sum_d = byte_sum;
            if (!seen_start_q) begin
              seen_start_d = 1'b1;
            end else begin
              interval_d     = arrival_time - last_start_q;
              second_start_d = 1'b1;
            end
            last_start_d = arrival_time;
            phase_d      = sfd_pkg::PH_HDR1;
          end else begin
            sum_d = '0;
          end
        end
        sfd_pkg::PH_HDR1: begin
          if (rx_byte == sfd_pkg::HDR1) begin
            sum_d   = byte_sum;
            phase_d = sfd_pkg::PH_HDR2;
          end else begin
            sum_d   = '0;
            phase_d = sfd_pkg::PH_HUNT;
          end
        end
        sfd_pkg::PH_HDR2: begin
          if (rx_byte == sfd_pkg::HDR2) begin
            sum_d   = byte_sum;
            phase_d = sfd_pkg::PH_HDR3;
          end else begin
            sum_d   = '0;
            phase_d = sfd_pkg::PH_HUNT;
          end
        end
        sfd_pkg::PH_HDR3: begin
          if (rx_byte == sfd_pkg::HDR3) begin
            sum_d   = byte_sum;
            phase_d = sfd_pkg::PH_PAYLOAD;
          end else begin
            sum_d   = '0;
            phase_d = sfd_pkg::PH_HUNT;
          end
        end
        sfd_pkg::PH_PAYLOAD: begin
          sum_d = byte_sum;
          if (cnt_q == sfd_pkg::CNT_W'(sfd_pkg::PAYLOAD_LEN - 1)) begin
            cnt_d   = '0;
            phase_d = sfd_pkg::PH_CHECK;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        sfd_pkg::PH_CHECK: begin
          frame_good = (byte_sum == '0);
          sum_d      = '0;
          phase_d    = sfd_pkg::PH_HUNT;
        end
        default: begin
          sum_d   = '0;
          phase_d = sfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= sfd_pkg::PH_HUNT;
      sum_q          <= '0;
      cnt_q          <= '0;
      seen_start_q   <= 1'b0;
      second_start_q <= 1'b0;
      last_start_q   <= '0;
      interval_q     <= '0;
    end else begin
      phase_q        <= phase_d;
      sum_q          <= sum_d;
      cnt_q          <= cnt_d;
      seen_start_q   <= seen_start_d;
      second_start_q <= second_start_d;
      last_start_q   <= last_start_d;
      interval_q     <= interval_d;
    end
  end

  // Payload bytes, written in arrival order
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[cnt_q] <= rx_byte;
    end
  end

  // Result register: loaded on a good checksum, emptied by the receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_good) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_good) begin
      out_data_q <= {interval_q, store_q[5], store_q[4], store_q[3],
                     store_q[2], store_q[1], store_q[0]};
      out_user_q <= second_start_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== sv/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the sensor frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [sfd_pkg::IN_W-1:0]   s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sfd_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tuser
);

  // A stalled result transaction holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Input back-pressure only when the result register is full and stalled
  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // A new result follows an accepted byte
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)
      |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an input transaction");

  // Without two start bytes the interval reads zero
  a_interval_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[79:48] == '0)
    else $error("interval non-zero before two starts");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for sensor_frame_deframer.
// ----------------------------------------------------------------------------
// Bytes are pushed into the slave stream with random arrival times. A local
// deframer model follows every accepted byte and queues the frame that each
// good checksum should produce. A separate process compares the master-stream
// transactions against that queue, field by field. Both streams idle at
// random, the receiver holds off once for a long stretch, and the sender
// pauses once until all queued frames are out.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [7:0]  HEADER [4]    = '{sfd_pkg::HDR0, sfd_pkg::HDR1,
                                            sfd_pkg::HDR2, sfd_pkg::HDR3};

  // One decoded frame as seen on the master stream
  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [15:0] altitude_one;
    logic [15:0] altitude_two;
    logic [7:0]  spare_byte;
    logic [31:0] frame_interval;
    logic        interval_valid;
  } frame_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [sfd_pkg::IN_W-1:0]  s_axis_tdata;   // [7:0] rx_byte, [39:8] arrival_time
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [sfd_pkg::OUT_W-1:0] m_axis_tdata;   // [7:0] flag_byte, [23:8] altitude_one,
                                             // [39:24] altitude_two,
                                             // [47:40] spare_byte,
                                             // [79:48] frame_interval
  logic                      m_axis_tuser;   // [0] interval_valid

  // Deframer model state
  sfd_pkg::phase_e deframe_phase;
  logic [7:0]      byte_sum;
  int unsigned     payload_idx;
  logic [7:0]      payload_bytes [sfd_pkg::PAYLOAD_LEN];
  bit              start_seen;
  bit              interval_known;
  logic [31:0]     last_start;
  logic [31:0]     start_interval;

  frame_result_t pending_frames [$];
  int unsigned   mismatches;
  int unsigned   cycle_count;

  // Stimulus knobs
  logic [31:0] now_us;
  logic [31:0] fixed_step;
  bit          tx_gaps_on;
  bit          rx_gaps_on;
  int unsigned rx_hold_cycles;

  sensor_frame_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Arrival time of the next byte: a fixed step when set, else small steps, odd large jumps
  function automatic logic [31:0] next_stamp();
    if (fixed_step != 0) begin
      now_us = now_us + fixed_step;
    end else begin
      case ($urandom_range(0, 49))
        0:       now_us = $urandom;
        1:       now_us = now_us + $urandom;
        default: now_us = now_us + $urandom_range(1, 200);
      endcase
    end
    return now_us;
  endfunction

  // ---------------------------------------------------------------------------
  // Deframer model
  // ---------------------------------------------------------------------------
  task automatic clear_model();
    deframe_phase  = sfd_pkg::PH_HUNT;
    byte_sum       = '0;
    payload_idx    = 0;
    start_seen     = 1'b0;
    interval_known = 1'b0;
    last_start     = '0;
    start_interval = '0;
    foreach (payload_bytes[i]) payload_bytes[i] = '0;
  endtask

  task automatic restart_hunt();
    deframe_phase = sfd_pkg::PH_HUNT;
    byte_sum      = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic [31:0] t);
    frame_result_t res;
    case (deframe_phase)
      sfd_pkg::PH_HUNT: begin
        if (b == sfd_pkg::HDR0) begin
          byte_sum = byte_sum + b;
          if (start_seen) begin
            start_interval = t - last_start;   // wraps modulo 2^32
            interval_known = 1'b1;
          end
          start_seen    = 1'b1;
          last_start    = t;
          deframe_phase = sfd_pkg::PH_HDR1;
        end else begin
          restart_hunt();
        end
      end
      sfd_pkg::PH_HDR1, sfd_pkg::PH_HDR2, sfd_pkg::PH_HDR3: begin
        if (b == HEADER[int'(deframe_phase)]) begin
          byte_sum      = byte_sum + b;
          deframe_phase = sfd_pkg::phase_e'(deframe_phase + 3'd1);
        end else begin
          restart_hunt();
        end
      end
      sfd_pkg::PH_PAYLOAD: begin
        payload_bytes[payload_idx] = b;
        byte_sum = byte_sum + b;
        payload_idx++;
        if (payload_idx >= sfd_pkg::PAYLOAD_LEN) begin
          payload_idx   = 0;
          deframe_phase = sfd_pkg::PH_CHECK;
        end
      end
      sfd_pkg::PH_CHECK: begin
        byte_sum = byte_sum + b;
        if (byte_sum == 8'd0) begin
          res.flag_byte      = payload_bytes[0];
          res.altitude_one   = {payload_bytes[2], payload_bytes[1]};
          res.altitude_two   = {payload_bytes[4], payload_bytes[3]};
          res.spare_byte     = payload_bytes[5];
          res.frame_interval = start_interval;
          res.interval_valid = interval_known;
          pending_frames.push_back(res);
        end
        restart_hunt();
      end
      default: restart_hunt();
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_byte(b, t);
  endtask

  task automatic tx_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_for_frames();
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  // Header, payload and checksum; a bad sum is off by a non-zero amount
  task automatic send_frame(input logic [7:0] pl [sfd_pkg::PAYLOAD_LEN], input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] chk;
    sum = '0;
    foreach (HEADER[k]) begin
      sum = sum + HEADER[k];
      send_byte(HEADER[k], next_stamp());
    end
    foreach (pl[k]) begin
      sum = sum + pl[k];
      send_byte(pl[k], next_stamp());
    end
    chk = 8'd0 - sum;
    if (bad_sum) chk = chk + 8'($urandom_range(1, 255));
    send_byte(chk, next_stamp());
  endtask

  // Header cut short at position pos by a wrong byte
  task automatic send_broken_header(input int unsigned pos);
    logic [7:0] wrong;
    for (int k = 0; k < pos; k++) send_byte(HEADER[k], next_stamp());
    if ($urandom_range(0, 2) == 0) begin
      wrong = sfd_pkg::HDR0;
    end else begin
      wrong = 8'($urandom);
      if (wrong == HEADER[pos]) wrong = ~wrong;
    end
    send_byte(wrong, next_stamp());
  endtask

  task automatic random_payload(output logic [7:0] pl [sfd_pkg::PAYLOAD_LEN]);
    int unsigned style;
    style = $urandom_range(0, 9);
    foreach (pl[k]) begin
      case (style)
        0:       pl[k] = 8'hFF;
        1:       pl[k] = 8'h00;
        default: pl[k] = 8'($urandom);
      endcase
    end
  endtask

  // Mostly good frames; bad sums, broken headers and line noise mixed in
  task automatic run_mixed_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned pos;
    int unsigned noise;
    logic [7:0]  pl [sfd_pkg::PAYLOAD_LEN];
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        random_payload(pl);
        send_frame(pl, 1'b0);
        sent += 11;
      end else if (pick < 80) begin
        random_payload(pl);
        send_frame(pl, 1'b1);
        sent += 11;
      end else if (pick < 90) begin
        pos = $urandom_range(1, 3);
        send_broken_header(pos);
        sent += pos + 1;
      end else begin
        noise = $urandom_range(1, 4);
        repeat (noise) send_byte(8'($urandom), next_stamp());
        sent += noise;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, or one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        stall = rx_gaps_on ? pick_gap() : 0;
        if (stall != 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: frame %h with none predicted", $time, m_axis_tdata);
      end else begin
        want = pending_frames.pop_front();
        check_field("flag_byte", want.flag_byte, m_axis_tdata[7:0]);
        check_field("altitude_one", want.altitude_one, m_axis_tdata[23:8]);
        check_field("altitude_two", want.altitude_two, m_axis_tdata[39:24]);
        check_field("spare_byte", want.spare_byte, m_axis_tdata[47:40]);
        check_field("frame_interval", want.frame_interval, m_axis_tdata[79:48]);
        check_field("interval_valid", want.interval_valid, m_axis_tuser);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First start with all-ones payload (arrival times wrap through zero), a second
  // start whose header an AA byte breaks, then an all-zeros frame
  task automatic test_directed_extremes();
    logic [7:0] pl [sfd_pkg::PAYLOAD_LEN];
    now_us     = 32'hFFFF_FF00;
    fixed_step = 32'h20;
    foreach (pl[k]) pl[k] = 8'hFF;
    send_frame(pl, 1'b0);
    send_byte(sfd_pkg::HDR0, next_stamp());
    send_byte(sfd_pkg::HDR1, next_stamp());
    send_byte(sfd_pkg::HDR0, next_stamp());   // wrong third byte, not a new start
    foreach (pl[k]) pl[k] = 8'h00;
    send_frame(pl, 1'b0);
    fixed_step = '0;
  endtask

  // Bad checksum gives nothing; the next frame still decodes
  task automatic test_bad_checksum();
    logic [7:0] pl [sfd_pkg::PAYLOAD_LEN];
    random_payload(pl);
    send_frame(pl, 1'b1);
    random_payload(pl);
    send_frame(pl, 1'b0);
  endtask

  task automatic test_random_stream();
    run_mixed_traffic(700);
  endtask

  // Stretch with no idling on either side
  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    run_mixed_traffic(300);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Receiver holds off while good frames stream in back to back
  task automatic test_output_backpressure();
    logic [7:0] pl [sfd_pkg::PAYLOAD_LEN];
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (6) begin
      random_payload(pl);
      send_frame(pl, 1'b0);
    end
    tx_gaps_on = 1'b1;
  endtask

  // Sender stops until every frame is out, then resumes
  task automatic test_drain_pause();
    run_mixed_traffic(60);
    tx_idle();
    wait_for_frames();
    run_mixed_traffic(60);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    mismatches     = 0;
    cycle_count    = 0;
    now_us         = '0;
    fixed_step     = '0;
    tx_gaps_on     = 1'b1;
    rx_gaps_on     = 1'b1;
    rx_hold_cycles = 0;
    clear_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_bad_checksum();
    test_random_stream();
    test_full_rate();
    test_output_backpressure();
    test_drain_pause();

    tx_idle();
    wait_for_frames();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += pending_frames.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sfd_pkg.sv
sv/sensor_frame_deframer.sv
sv/sfd_checker.sv
tb/sv/tb.sv
